FILE: rtl/core/hslrgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared constants and types for the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CHAN_W        = 8;

	// per-stage load enables of the pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	// piece of the hue ramp
	typedef enum logic [1:0] {
		PIECE_RISE = 2'd0,
		PIECE_HIGH = 2'd1,
		PIECE_FALL = 2'd2,
		PIECE_LOW  = 2'd3
	} piece_t;

	// hue offset of a channel lane
	typedef enum logic [1:0] {
		OFS_PLUS  = 2'd0,
		OFS_ZERO  = 2'd1,
		OFS_MINUS = 2'd2
	} ofs_t;

endpackage

FILE: rtl/core/hslrgb_qp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_qp
// Stages 1 and 2: clamps saturation and lightness, forms l*s, then q, p, q-p.
// ----------------------------------------------------------------------------
module hslrgb_qp #(
	parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  hslrgb_pkg::pipe_en_t   en,
	input  logic [FRAC_BITS:0]     hue,
	input  logic [FRAC_BITS:0]     saturation,
	input  logic [FRAC_BITS:0]     lightness,
	output logic [FRAC_BITS-1:0]   h_s2,
	output logic [FRAC_BITS:0]     l_s2,
	output logic [FRAC_BITS:0]     q_s2,
	output logic [FRAC_BITS:0]     p_s2,
	output logic [FRAC_BITS:0]     d_s2,
	output logic                   gray_s2
);

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] HALF = W'(1) << (FRAC_BITS - 1);

	logic [W-1:0]     s_sat;
	logic [W-1:0]     l_sat;
	logic [2*W-1:0]   ls_prod;

	logic [FRAC_BITS-1:0] h_s1;
	logic [W-1:0]         s_s1;
	logic [W-1:0]         l_s1;
	logic [W-1:0]         ls_s1;
	logic                 gray_s1;

	logic         low_half;
	logic [W:0]   q_wide;
	logic [W-1:0] s_minus_ls;
	logic [W-1:0] q_val;
	logic [W-1:0] d_val;
	logic [W-1:0] p_val;

	assign s_sat   = (saturation > ONE) ? ONE : saturation;
	assign l_sat   = (lightness > ONE) ? ONE : lightness;
	assign ls_prod = {{W{1'b0}}, l_sat} * {{W{1'b0}}, s_sat};

	always_ff @(posedge clk) begin
		if (en.s1) begin
			h_s1    <= hue[FRAC_BITS-1:0];
			s_s1    <= s_sat;
			l_s1    <= l_sat;
			ls_s1   <= ls_prod[2*FRAC_BITS:FRAC_BITS];
			gray_s1 <= (s_sat == '0);
		end
	end

	assign low_half   = (l_s1 < HALF);
	assign s_minus_ls = s_s1 - ls_s1;

	always_comb begin
		if (low_half) begin
			q_wide = {1'b0, l_s1} + {1'b0, ls_s1};
			d_val  = {ls_s1[W-2:0], 1'b0};
		end else begin
			q_wide = {1'b0, l_s1} + {1'b0, s_minus_ls};
			d_val  = {s_minus_ls[W-2:0], 1'b0};
		end
	end

	assign q_val = q_wide[W-1:0];
	assign p_val = q_val - d_val;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			h_s2    <= h_s1;
			l_s2    <= l_s1;
			q_s2    <= q_val;
			p_s2    <= p_val;
			d_s2    <= d_val;
			gray_s2 <= gray_s1;
		end
	end

endmodule

FILE: rtl/core/hslrgb_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hslrgb_lane
// Stages 3 to 5 of one color channel: hue position and ramp piece, ramp
// multiply, scaling to an 8-bit intensity.
// ----------------------------------------------------------------------------
module hslrgb_lane #(
	parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  hslrgb_pkg::pipe_en_t           en,
	input  hslrgb_pkg::ofs_t               ofs,
	input  logic [FRAC_BITS-1:0]           h_s2,
	input  logic [FRAC_BITS:0]             l_s2,
	input  logic [FRAC_BITS:0]             q_s2,
	input  logic [FRAC_BITS:0]             p_s2,
	input  logic [FRAC_BITS:0]             d_s2,
	input  logic                           gray_s2,
	output logic [hslrgb_pkg::CHAN_W-1:0]  chan_s5
);

	localparam int W  = FRAC_BITS + 1;
	localparam int TW = FRAC_BITS + 3;
	localparam int TU = FRAC_BITS + 2;
	localparam int SW = W + hslrgb_pkg::CHAN_W;

	localparam logic [TW-1:0] ONE_T       = TW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] THREE_T     = TW'(3) << FRAC_BITS;
	localparam logic [TU-1:0] HALF_U      = TU'(1) << (FRAC_BITS - 1);
	localparam logic [TU-1:0] THREEHALF_U = TU'(3) << (FRAC_BITS - 1);
	localparam logic [TU-1:0] TWO_U       = TU'(1) << (FRAC_BITS + 1);

	logic [TW-1:0] h3;
	logic [TW-1:0] t_raw;
	logic [TW-1:0] t_wrap;
	logic [TU-1:0] t_pos;
	logic [TU-1:0] fall_d;
	hslrgb_pkg::piece_t piece;
	logic [W-1:0]  x_val;

	hslrgb_pkg::piece_t piece_s3;
	logic [W-1:0] x_s3;
	logic [W-1:0] l_s3;
	logic [W-1:0] q_s3;
	logic [W-1:0] p_s3;
	logic [W-1:0] d_s3;
	logic         gray_s3;

	logic [2*W-1:0] ramp_prod;
	logic [W:0]     ramp_sum;
	logic [W-1:0]   v_val;
	logic [W-1:0]   v_s4;

	logic [SW-1:0]  scaled;
	logic [SW-FRAC_BITS-1:0] scaled_top;

	// hue position scaled by three, so a third of a turn is one
	assign h3 = {3'b000, h_s2} + {2'b00, h_s2, 1'b0};

	always_comb begin
		unique case (ofs)
			hslrgb_pkg::OFS_PLUS:  t_raw = h3 + ONE_T;
			hslrgb_pkg::OFS_ZERO:  t_raw = h3;
			hslrgb_pkg::OFS_MINUS: t_raw = h3 - ONE_T;
			default:               t_raw = h3;
		endcase
	end

	always_comb begin
		priority if (t_raw[TW-1]) begin
			t_wrap = t_raw + THREE_T;
		end else if (t_raw > THREE_T) begin
			t_wrap = t_raw - THREE_T;
		end else begin
			t_wrap = t_raw;
		end
	end

	assign t_pos  = t_wrap[TU-1:0];
	assign fall_d = TWO_U - t_pos;

	always_comb begin
		priority if (t_pos < HALF_U) begin
			piece = hslrgb_pkg::PIECE_RISE;
			x_val = {t_pos[FRAC_BITS-1:0], 1'b0};
		end else if (t_pos < THREEHALF_U) begin
			piece = hslrgb_pkg::PIECE_HIGH;
			x_val = '0;
		end else if (t_pos < TWO_U) begin
			piece = hslrgb_pkg::PIECE_FALL;
			x_val = {fall_d[FRAC_BITS-1:0], 1'b0};
		end else begin
			piece = hslrgb_pkg::PIECE_LOW;
			x_val = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			piece_s3 <= piece;
			x_s3     <= x_val;
			l_s3     <= l_s2;
			q_s3     <= q_s2;
			p_s3     <= p_s2;
			d_s3     <= d_s2;
			gray_s3  <= gray_s2;
		end
	end

	assign ramp_prod = {{W{1'b0}}, d_s3} * {{W{1'b0}}, x_s3};
	assign ramp_sum  = {1'b0, p_s3} + {1'b0, ramp_prod[2*FRAC_BITS:FRAC_BITS]};

	always_comb begin
		if (gray_s3) begin
			v_val = l_s3;
		end else begin
			unique case (piece_s3)
				hslrgb_pkg::PIECE_RISE,
				hslrgb_pkg::PIECE_FALL: v_val = ramp_sum[W-1:0];
				hslrgb_pkg::PIECE_HIGH: v_val = q_s3;
				hslrgb_pkg::PIECE_LOW:  v_val = p_s3;
				default:                v_val = p_s3;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			v_s4 <= v_val;
		end
	end

	// times 255, then drop the fraction
	assign scaled     = {v_s4, {hslrgb_pkg::CHAN_W{1'b0}}} - {{hslrgb_pkg::CHAN_W{1'b0}}, v_s4};
	assign scaled_top = scaled[SW-1:FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en.s5) begin
			chan_s5 <= scaled_top[SW-FRAC_BITS-1] ? {hslrgb_pkg::CHAN_W{1'b1}}
			                                      : scaled_top[hslrgb_pkg::CHAN_W-1:0];
		end
	end

endmodule

FILE: rtl/core/hsl_to_rgb_converter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter_top
// HSL to RGB pixel converter, five-stage pipeline, one pixel per clock while drained.
//
//   channel  handshake                payload
//   pix      pix_valid / pix_ready    hue, saturation, lightness
//   rgb      rgb_valid / rgb_ready    red, green, blue
//
// rgb_valid rises once an accepted word has passed stage registers 1 to 5, so
// the word leaves from stage 5; a new word is taken every cycle while the
// output is drained.
// Stage enables ripple back from rgb_ready, so an empty stage takes a word
// even while later stages are stalled.
// arst_n clears the stage valid bits only; data registers hold no reset.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter_top #(
	parameter int FRAC_BITS = hslrgb_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_ready,
	input  logic [FRAC_BITS:0]             hue,
	input  logic [FRAC_BITS:0]             saturation,
	input  logic [FRAC_BITS:0]             lightness,
	output logic                           rgb_valid,
	input  logic                           rgb_ready,
	output logic [hslrgb_pkg::CHAN_W-1:0]  red,
	output logic [hslrgb_pkg::CHAN_W-1:0]  green,
	output logic [hslrgb_pkg::CHAN_W-1:0]  blue
);

	hslrgb_pkg::pipe_en_t en;

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic vld_s5;

	logic [FRAC_BITS-1:0] h_s2;
	logic [FRAC_BITS:0]   l_s2;
	logic [FRAC_BITS:0]   q_s2;
	logic [FRAC_BITS:0]   p_s2;
	logic [FRAC_BITS:0]   d_s2;
	logic                 gray_s2;

	assign en.s5 = !vld_s5 || rgb_ready;
	assign en.s4 = !vld_s4 || en.s5;
	assign en.s3 = !vld_s3 || en.s4;
	assign en.s2 = !vld_s2 || en.s3;
	assign en.s1 = !vld_s1 || en.s2;

	assign pix_ready = en.s1;
	assign rgb_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= pix_valid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
		end
	end

	hslrgb_qp #(
		.FRAC_BITS(FRAC_BITS)
	) u_qp (
		.clk       (clk),
		.en        (en),
		.hue       (hue),
		.saturation(saturation),
		.lightness (lightness),
		.h_s2      (h_s2),
		.l_s2      (l_s2),
		.q_s2      (q_s2),
		.p_s2      (p_s2),
		.d_s2      (d_s2),
		.gray_s2   (gray_s2)
	);

	hslrgb_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_red (
		.clk    (clk),
		.en     (en),
		.ofs    (hslrgb_pkg::OFS_PLUS),
		.h_s2   (h_s2),
		.l_s2   (l_s2),
		.q_s2   (q_s2),
		.p_s2   (p_s2),
		.d_s2   (d_s2),
		.gray_s2(gray_s2),
		.chan_s5(red)
	);

	hslrgb_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_green (
		.clk    (clk),
		.en     (en),
		.ofs    (hslrgb_pkg::OFS_ZERO),
		.h_s2   (h_s2),
		.l_s2   (l_s2),
		.q_s2   (q_s2),
		.p_s2   (p_s2),
		.d_s2   (d_s2),
		.gray_s2(gray_s2),
		.chan_s5(green)
	);

	hslrgb_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_blue (
		.clk    (clk),
		.en     (en),
		.ofs    (hslrgb_pkg::OFS_MINUS),
		.h_s2   (h_s2),
		.l_s2   (l_s2),
		.q_s2   (q_s2),
		.p_s2   (p_s2),
		.d_s2   (d_s2),
		.gray_s2(gray_s2),
		.chan_s5(blue)
	);

`ifndef NO_ASSERTIONS
	// full pipeline with a stalled output must not take a word
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && !rgb_ready) |-> !pix_ready)
		else $error("pix_ready high with full stalled pipeline");

	// an accepted word lands in stage 1
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_ready) |=> vld_s1)
		else $error("accepted word missing in stage 1");

	// a held stage keeps its word
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !en.s4) |=> vld_s4)
		else $error("stalled word dropped in stage 4");

	// a word in the last stage leaves only when taken
	a_hold_s5: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s5 && !rgb_ready) |=> vld_s5)
		else $error("output word dropped while stalled");
`endif

endmodule
